@@ rtl/fmc_pkg.sv @@
// ----------------------------------------------------------------------------
// fmc_pkg
// Shared types, codes and helpers for the fountain mode controller.
// ----------------------------------------------------------------------------
package fmc_pkg;

    localparam int PERIOD_W = 20;
    localparam int TIMER_W  = 16;
    localparam int DRV_W    = 4;
    localparam int INDEX_W  = 2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 20'd172800;
    localparam logic [TIMER_W-1:0]  SETTLE_RESET = 16'd20;
    localparam logic [TIMER_W-1:0]  FILL_RESET   = 16'd120;

    localparam logic [INDEX_W-1:0] REG_DRAIN_PERIOD = 2'd0;
    localparam logic [INDEX_W-1:0] REG_SETTLE_LIMIT = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FILL_LIMIT   = 2'd2;

    // drive level bit positions
    localparam int DRV_FILL  = 0;
    localparam int DRV_CIRC  = 1;
    localparam int DRV_VALVE = 2;
    localparam int DRV_UV    = 3;

    localparam logic [1:0] RUN_IDLE  = 2'd0;
    localparam logic [1:0] RUN_CIRC  = 2'd1;
    localparam logic [1:0] RUN_DRAIN = 2'd2;
    localparam logic [1:0] RUN_FILL  = 2'd3;

    typedef enum logic [3:0] {
        MODE_IDLE  = 4'b0001,
        MODE_CIRC  = 4'b0010,
        MODE_DRAIN = 4'b0100,
        MODE_FILL  = 4'b1000
    } mode_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] drain_period_ticks;
        logic [TIMER_W-1:0]  settle_limit_ticks;
        logic [TIMER_W-1:0]  fill_limit_ticks;
    } fmc_cfg_t;

    typedef struct packed {
        logic drain_key_long;
        logic service_hold;
        logic is_night;
        logic pet_present;
        logic waste_tank_full;
        logic bowl_at_high;
        logic bowl_below_low;
        logic clean_tank_has_water;
    } fmc_in_t;

    typedef struct packed {
        mode_t               mode;
        logic [PERIOD_W-1:0] drain_countdown;
        logic [TIMER_W-1:0]  settle_timer;
        logic [TIMER_W-1:0]  fill_timer;
        logic                valve_opened_flag;
        logic [DRV_W-1:0]    drive_levels;
    } fmc_state_t;

    function automatic logic [1:0] mode_code(input mode_t m);
        logic [1:0] c;
        case (m)
            MODE_IDLE:  c = RUN_IDLE;
            MODE_CIRC:  c = RUN_CIRC;
            MODE_DRAIN: c = RUN_DRAIN;
            MODE_FILL:  c = RUN_FILL;
            default:    c = RUN_IDLE;
        endcase
        return c;
    endfunction

endpackage

@@ rtl/fmc_cfg.sv @@
// ----------------------------------------------------------------------------
// fmc_cfg
// Configuration registers: drain period, settle limit and fill limit.
// ----------------------------------------------------------------------------
module fmc_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic [fmc_pkg::INDEX_W-1:0]   cfg_index,
    input  logic [fmc_pkg::PERIOD_W-1:0]  cfg_data,
    output fmc_pkg::fmc_cfg_t             cfg
);

    fmc_pkg::fmc_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.drain_period_ticks <= fmc_pkg::PERIOD_RESET;
            cfg_reg.settle_limit_ticks <= fmc_pkg::SETTLE_RESET;
            cfg_reg.fill_limit_ticks   <= fmc_pkg::FILL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                fmc_pkg::REG_DRAIN_PERIOD: cfg_reg.drain_period_ticks <= cfg_data;
                fmc_pkg::REG_SETTLE_LIMIT:
                    cfg_reg.settle_limit_ticks <= cfg_data[fmc_pkg::TIMER_W-1:0];
                fmc_pkg::REG_FILL_LIMIT:
                    cfg_reg.fill_limit_ticks <= cfg_data[fmc_pkg::TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/fmc_step.sv @@
// ----------------------------------------------------------------------------
// fmc_step
// Next-state logic for one tick: UV rule, drain key, mode step, countdown.
// ----------------------------------------------------------------------------
module fmc_step (
    input  fmc_pkg::fmc_state_t cur,
    input  fmc_pkg::fmc_in_t    in_item,
    input  fmc_pkg::fmc_cfg_t   cfg,
    output fmc_pkg::fmc_state_t nxt
);

    fmc_pkg::mode_t               mode_v;
    logic [fmc_pkg::TIMER_W-1:0]  settle_inc;
    logic [fmc_pkg::TIMER_W-1:0]  fill_inc;
    logic                         drain_done;

    assign settle_inc = cur.settle_timer + 1'b1;
    assign fill_inc   = cur.fill_timer + 1'b1;

    always_comb
    begin
        nxt        = cur;
        mode_v     = cur.mode;
        drain_done = 1'b0;
        if (!in_item.service_hold)
        begin
            if (!in_item.bowl_below_low && !in_item.pet_present)
            begin
                if (!in_item.is_night)
                    nxt.drive_levels[fmc_pkg::DRV_UV] = 1'b1;
            end
            else
            begin
                nxt.drive_levels[fmc_pkg::DRV_UV] = 1'b0;
            end

            if (in_item.drain_key_long)
            begin
                mode_v              = fmc_pkg::MODE_DRAIN;
                nxt.drain_countdown = '0;
            end

            nxt.mode = fmc_pkg::MODE_IDLE;
            case (mode_v)
                fmc_pkg::MODE_IDLE:
                begin
                    if (in_item.clean_tank_has_water && in_item.bowl_below_low)
                        nxt.mode = fmc_pkg::MODE_FILL;
                    else if (!in_item.bowl_below_low && in_item.pet_present)
                        nxt.mode = fmc_pkg::MODE_CIRC;
                    else if (nxt.drain_countdown == '0)
                        nxt.mode = fmc_pkg::MODE_DRAIN;
                end
                fmc_pkg::MODE_CIRC:
                begin
                    nxt.drive_levels[fmc_pkg::DRV_FILL]  = 1'b0;
                    nxt.drive_levels[fmc_pkg::DRV_CIRC]  = 1'b1;
                    nxt.drive_levels[fmc_pkg::DRV_VALVE] = 1'b0;
                end
                fmc_pkg::MODE_DRAIN:
                begin
                    if (nxt.drain_countdown == '0)
                    begin
                        nxt.drive_levels[fmc_pkg::DRV_FILL] = 1'b0;
                        nxt.drive_levels[fmc_pkg::DRV_CIRC] = 1'b0;
                        if (!cur.valve_opened_flag && !in_item.waste_tank_full)
                        begin
                            nxt.drive_levels[fmc_pkg::DRV_VALVE] = 1'b1;
                            nxt.valve_opened_flag                = 1'b1;
                        end
                        if (in_item.waste_tank_full)
                        begin
                            drain_done = 1'b1;
                        end
                        else if (in_item.bowl_below_low)
                        begin
                            nxt.settle_timer = settle_inc;
                            if (settle_inc > cfg.settle_limit_ticks)
                                drain_done = 1'b1;
                            else
                                nxt.mode = fmc_pkg::MODE_DRAIN;
                        end
                        if (drain_done)
                        begin
                            nxt.settle_timer                     = '0;
                            nxt.drive_levels[fmc_pkg::DRV_VALVE] = 1'b0;
                            nxt.drain_countdown                  = cfg.drain_period_ticks;
                            nxt.valve_opened_flag                = 1'b0;
                        end
                    end
                end
                fmc_pkg::MODE_FILL:
                begin
                    if (!in_item.clean_tank_has_water)
                    begin
                        nxt.drive_levels[fmc_pkg::DRV_FILL] = 1'b0;
                    end
                    else if (!in_item.bowl_at_high)
                    begin
                        nxt.drive_levels[fmc_pkg::DRV_CIRC] = 1'b0;
                        if (fill_inc > cfg.fill_limit_ticks)
                        begin
                            nxt.fill_timer                      = '0;
                            nxt.drive_levels[fmc_pkg::DRV_FILL] = 1'b0;
                        end
                        else
                        begin
                            nxt.fill_timer                      = fill_inc;
                            nxt.drive_levels[fmc_pkg::DRV_FILL] = 1'b1;
                            nxt.mode                            = fmc_pkg::MODE_FILL;
                        end
                    end
                    else
                    begin
                        nxt.drive_levels[fmc_pkg::DRV_FILL] = 1'b0;
                        nxt.drive_levels[fmc_pkg::DRV_CIRC] = 1'b0;
                    end
                end
                default: ;
            endcase

            if (nxt.drain_countdown != '0)
                nxt.drain_countdown = nxt.drain_countdown - 1'b1;
        end
    end

endmodule

@@ rtl/fountain_mode_controller.sv @@
// ----------------------------------------------------------------------------
// fountain_mode_controller
// Pet fountain mode controller: one sensor sample in, one drive/mode item out.
// ----------------------------------------------------------------------------
// The result is valid in the output register in the cycle after input accept.
// Throughput: 1 item per cycle while the receiver takes results; the state update is a single pass of fmc_step
// between the state registers and the output register.
// Reset (rst_n low, async): mode idle, drive levels off, timers and valve flag
// cleared, config at defaults, drain countdown loaded with the default period.
module fountain_mode_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [0] clean_tank_has_water [1] bowl_below_low [2] bowl_at_high
    // [3] waste_tank_full [4] pet_present [5] is_night [6] service_hold
    // [7] drain_key_long
    input  logic [7:0]  s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] fill_pump_on [1] circulate_pump_on [2] drain_valve_open
    // [3] uv_lamp_on [5:4] run_mode [7:6] zero
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data
);

    fmc_pkg::fmc_cfg_t   cfg;
    fmc_pkg::fmc_in_t    in_item;
    fmc_pkg::fmc_state_t state_reg;
    fmc_pkg::fmc_state_t state_next;
    logic                out_valid_reg;
    logic [7:0]          out_data_reg;
    logic                accept;

    assign cfg_ready = 1'b1;

    fmc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    assign in_item = s_tdata;

    fmc_step u_step (
        .cur     (state_reg),
        .in_item (in_item),
        .cfg     (cfg),
        .nxt     (state_next)
    );

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode              <= fmc_pkg::MODE_IDLE;
            state_reg.drain_countdown   <= fmc_pkg::PERIOD_RESET;
            state_reg.settle_timer      <= '0;
            state_reg.fill_timer        <= '0;
            state_reg.valve_opened_flag <= 1'b0;
            state_reg.drive_levels      <= '0;
            out_valid_reg               <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= {2'b00, fmc_pkg::mode_code(state_next.mode),
                             state_next.drive_levels};
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ test/fmc_checker.sv @@
// ----------------------------------------------------------------------------
// fmc_checker
// Watches the sample, result and register channels of the fountain mode
// controller, keeps its own copy of the mode machine, drive levels, timers and
// settings, and compares every result item field by field against the oldest
// prediction. Reports failures, results still due, results checked and drain/fill counts.
// ----------------------------------------------------------------------------
module fmc_checker
    import fmc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [19:0] cfg_data,
    output int          failures,
    output int          outstanding,
    output int          checked,
    output int          drain_results,
    output int          fill_results
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [PERIOD_W-1:0] period_set;
    logic [TIMER_W-1:0]  settle_set;
    logic [TIMER_W-1:0]  fill_set;

    logic [1:0]          run_mode;
    logic [PERIOD_W-1:0] countdown;
    logic [TIMER_W-1:0]  settle_cnt;
    logic [TIMER_W-1:0]  fill_cnt;
    logic                valve_opened;
    logic [DRV_W-1:0]    drive;

    logic [7:0] predicted_results[$];

    task automatic report(input string field, input int want, input int got);
        $display("fmc_checker: result %0d field %s expected %0d got %0d",
                 checked, field, want, got);
        failures++;
    endtask

    task automatic close_drain();
        settle_cnt      = '0;
        drive[DRV_VALVE] = 1'b0;
        countdown       = period_set;
        valve_opened    = 1'b0;
    endtask

    task automatic tick_fountain(input fmc_in_t smp, output logic [7:0] res);
        logic [1:0] nxt;
        if (!smp.service_hold)
        begin
            nxt = RUN_IDLE;
            if (!smp.bowl_below_low && !smp.pet_present)
            begin
                if (!smp.is_night)
                    drive[DRV_UV] = 1'b1;
            end
            else
                drive[DRV_UV] = 1'b0;

            if (smp.drain_key_long)
            begin
                run_mode  = RUN_DRAIN;
                countdown = '0;
            end

            case (run_mode)
                RUN_IDLE:
                begin
                    if (smp.clean_tank_has_water && smp.bowl_below_low)
                        nxt = RUN_FILL;
                    else if (!smp.bowl_below_low && smp.pet_present)
                        nxt = RUN_CIRC;
                    else if (countdown == '0)
                        nxt = RUN_DRAIN;
                end
                RUN_CIRC:
                begin
                    drive[DRV_FILL]  = 1'b0;
                    drive[DRV_CIRC]  = 1'b1;
                    drive[DRV_VALVE] = 1'b0;
                end
                RUN_DRAIN:
                begin
                    if (countdown == '0)
                    begin
                        drive[DRV_FILL] = 1'b0;
                        drive[DRV_CIRC] = 1'b0;
                        if (!valve_opened && !smp.waste_tank_full)
                        begin
                            drive[DRV_VALVE] = 1'b1;
                            valve_opened     = 1'b1;
                        end
                        if (smp.waste_tank_full)
                            close_drain();
                        else if (smp.bowl_below_low)
                        begin
                            settle_cnt = settle_cnt + 1'b1;
                            if (settle_cnt > settle_set)
                                close_drain();
                            else
                                nxt = RUN_DRAIN;
                        end
                    end
                end
                default:
                begin
                    if (!smp.clean_tank_has_water)
                        drive[DRV_FILL] = 1'b0;
                    else if (!smp.bowl_at_high)
                    begin
                        drive[DRV_FILL] = 1'b1;
                        drive[DRV_CIRC] = 1'b0;
                        fill_cnt = fill_cnt + 1'b1;
                        if (fill_cnt > fill_set)
                        begin
                            fill_cnt        = '0;
                            drive[DRV_FILL] = 1'b0;
                            drive[DRV_CIRC] = 1'b0;
                        end
                        else
                            nxt = RUN_FILL;
                    end
                    else
                    begin
                        drive[DRV_FILL] = 1'b0;
                        drive[DRV_CIRC] = 1'b0;
                    end
                end
            endcase
            run_mode = nxt;
            if (countdown != '0)
                countdown = countdown - 1'b1;
        end
        res = {2'b00, run_mode, drive};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [7:0] want;
        logic [7:0] res;
        if (!rst_n)
        begin
            period_set   = PERIOD_RESET;
            settle_set   = SETTLE_RESET;
            fill_set     = FILL_RESET;
            run_mode     = RUN_IDLE;
            countdown    = PERIOD_RESET;
            settle_cnt   = '0;
            fill_cnt     = '0;
            valve_opened = 1'b0;
            drive        = '0;
            predicted_results.delete();
            failures      = 0;
            checked       = 0;
            drain_results = 0;
            fill_results  = 0;
            outstanding  <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_DRAIN_PERIOD: period_set = cfg_data;
                    REG_SETTLE_LIMIT: settle_set = cfg_data[TIMER_W-1:0];
                    REG_FILL_LIMIT:   fill_set   = cfg_data[TIMER_W-1:0];
                    default: ;
                endcase
            end

            if (m_tvalid && m_tready)
            begin
                if (predicted_results.size() == 0)
                begin
                    $display("fmc_checker: unexpected result item %02h", m_tdata);
                    failures++;
                end
                else
                begin
                    want = predicted_results.pop_front();
                    if (m_tdata[0] !== want[0])
                        report("fill_pump_on", want[0], m_tdata[0]);
                    if (m_tdata[1] !== want[1])
                        report("circulate_pump_on", want[1], m_tdata[1]);
                    if (m_tdata[2] !== want[2])
                        report("drain_valve_open", want[2], m_tdata[2]);
                    if (m_tdata[3] !== want[3])
                        report("uv_lamp_on", want[3], m_tdata[3]);
                    if (m_tdata[5:4] !== want[5:4])
                        report("run_mode", want[5:4], m_tdata[5:4]);
                    if (m_tdata[7:6] !== 2'b00)
                        report("pad", 0, m_tdata[7:6]);
                    if (want[5:4] == RUN_DRAIN)
                        drain_results++;
                    if (want[5:4] == RUN_FILL)
                        fill_results++;
                end
                checked++;
            end

            if (s_tvalid && s_tready)
            begin
                tick_fountain(fmc_in_t'(s_tdata), res);
                predicted_results.push_back(res);
            end

            outstanding <= predicted_results.size();
        end
    end

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives the fountain mode controller with a short directed sequence and then
// biased random sensor samples under several register settings, with bursty
// input traffic and a stalling receiver. Checking is done in fmc_checker.
// ----------------------------------------------------------------------------
module tb_top;
    import fmc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [7:0]  s_tdata   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = REG_DRAIN_PERIOD;
    logic [19:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [7:0]  m_tdata;
    logic        cfg_ready;

    int failures;
    int outstanding;
    int checked;
    int drain_results;
    int fill_results;

    int samples_sent = 0;
    int settings_used = 0;
    int bias[8];
    int rx_left = 0;
    logic [1:0] rx_style = 2'd0;

    logic [7:0] directed_samples[$] = '{
        8'h00, 8'h20, 8'h10, 8'h00, 8'h03, 8'h03, 8'h05, 8'h03,
        8'h02, 8'h80, 8'h02, 8'h02, 8'h02, 8'h08, 8'h40, 8'hFF,
        8'hBF, 8'h82, 8'h8A, 8'h01, 8'h0C, 8'h30, 8'h24, 8'h60
    };

    fountain_mode_controller dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fmc_checker mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .failures      (failures),
        .outstanding   (outstanding),
        .checked       (checked),
        .drain_results (drain_results),
        .fill_results  (fill_results)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("tb_top: timeout with %0d results outstanding", outstanding);
        $display("tb_top: FAIL");
        $finish;
    end

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // receiver: switches between ready, random and periodic stall patterns
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_style <= 2'($urandom_range(3));
            rx_left  <= $urandom_range(20, 120);
        end
        else
            rx_left <= rx_left - 1;
        case (rx_style)
            2'd0:    m_tready <= 1'b1;
            2'd1:    m_tready <= chance(70);
            2'd2:    m_tready <= chance(25);
            default: m_tready <= (rx_left[1:0] == 2'd0);
        endcase
    end

    task automatic push_sample(input logic [7:0] d);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [19:0] d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // 16-bit limits go out with junk in the unused upper data bits
    task automatic apply_setting(input logic [19:0] period, input logic [15:0] settle,
                                 input logic [15:0] fill);
        write_reg(REG_DRAIN_PERIOD, period);
        write_reg(REG_SETTLE_LIMIT, {4'($urandom_range(15)), settle});
        write_reg(REG_FILL_LIMIT, {4'($urandom_range(15)), fill});
        settings_used++;
    endtask

    function automatic int level_bias();
        case ($urandom_range(2))
            0:       return 3;
            1:       return 50;
            default: return 97;
        endcase
    endfunction

    task automatic new_profile();
        for (int b = 0; b < 6; b++)
            bias[b] = level_bias();
        bias[6] = chance(50) ? 0 : ($urandom_range(1) ? 2 : 15);
        bias[7] = chance(50) ? 0 : ($urandom_range(1) ? 1 : 4);
    endtask

    function automatic logic [7:0] make_sample();
        logic [7:0] d;
        if (chance(10))
            return 8'($urandom);
        for (int b = 0; b < 8; b++)
            d[b] = chance(bias[b]);
        return d;
    endfunction

    task automatic run_random(input int count);
        int done;
        int len;
        int gap;
        logic [7:0] d;
        done = 0;
        while (done < count)
        begin
            new_profile();
            len = $urandom_range(1, 40);
            gap = chance(30) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                d = make_sample();
                push_sample(d);
                if (!d[6])
                    done++;
            end
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_samples[i])
            push_sample(directed_samples[i]);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: apply_setting(20'd0, 16'd0, 16'd0);
                1: apply_setting(20'hFFFFF, 16'd65534, 16'd65534);
                2: apply_setting(PERIOD_RESET, SETTLE_RESET, FILL_RESET);
                default:
                    apply_setting(20'($urandom_range(0, 60)), 16'($urandom_range(0, 12)),
                                  16'($urandom_range(0, 15)));
            endcase
            if (ph == 3)
                write_reg(2'd3, 20'($urandom));
            run_random(200);
            wait_quiet();
        end

        repeat (10) @(posedge clk);
        $display("tb_top: %0d samples sent, %0d results checked, %0d register settings",
                 samples_sent, checked, settings_used);
        $display("tb_top: %0d results in drain mode, %0d in fill mode",
                 drain_results, fill_results);
        if (failures == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
